@@ hw/rtl/cpfc_pkg.sv @@
// Shared types, constants and codes for the capped prime factor counter.
`timescale 1ns / 1ps

package cpfc_pkg;

  localparam int NUMBER_BITS   = 31;
  localparam int COUNT_BITS    = 5;
  localparam int CAP_BITS      = 5;
  localparam int PCT_BITS      = 7;
  localparam int CFG_DATA_BITS = 7;
  localparam int DIV_CNT_BITS  = $clog2(NUMBER_BITS);
  localparam int PROD_BITS     = NUMBER_BITS + PCT_BITS;

  typedef logic [NUMBER_BITS-1:0] num_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [CAP_BITS-1:0]    cap_t;
  typedef logic [PCT_BITS-1:0]    pct_t;
  typedef logic [PROD_BITS-1:0]   prod_t;

  localparam count_t COUNT_MAX   = '1;
  localparam count_t COUNT_SEMI  = COUNT_BITS'(2);
  localparam cap_t   CAP_RESET   = CAP_BITS'(5);
  localparam pct_t   PCT_RESET   = PCT_BITS'(1);
  localparam pct_t   PCT_FULL    = PCT_BITS'(100);
  localparam num_t   FACTOR_TWO  = NUMBER_BITS'(2);
  localparam num_t   FACTOR_THREE = NUMBER_BITS'(3);
  localparam num_t   FIRST_WHEEL = NUMBER_BITS'(5);
  localparam num_t   WHEEL_STEP  = NUMBER_BITS'(6);
  localparam num_t   NUM_ONE     = NUMBER_BITS'(1);

  typedef enum logic {
    REG_FACTOR_CAP = 1'b0,
    REG_CLOSENESS  = 1'b1
  } reg_idx_t;

  // Which divisor the current trial division uses.
  typedef enum logic [2:0] {
    PH_TWO,
    PH_THREE,
    PH_TOP,
    PH_P,
    PH_P2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LAUNCH,
    S_WAIT,
    S_EVAL,
    S_FINAL,
    S_PROD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic   load;
    logic   launch;
    phase_t sel;
    logic   accept;
    logic   advance_p;
    logic   final_note;
    logic   prod;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic q_ge_d;
    logic rest_one;
    logic rest_zero;
    logic below_cap;
  } dp_status_t;

endpackage

@@ hw/rtl/cpfc_ifs.sv @@
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps

interface cpfc_req_if;
  import cpfc_pkg::*;
  logic valid;
  logic ready;
  num_t number;
  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface cpfc_rsp_if;
  import cpfc_pkg::*;
  logic   valid;
  logic   ready;
  count_t factor_count;
  logic   complete;
  logic   k_almost;
  logic   semiprime;
  num_t   first_factor;
  num_t   second_factor;
  logic   interesting;
  modport source (output valid, output factor_count, output complete, output k_almost,
                  output semiprime, output first_factor, output second_factor,
                  output interesting, input ready);
  modport sink (input valid, input factor_count, input complete, input k_almost,
                input semiprime, input first_factor, input second_factor,
                input interesting, output ready);
endinterface

interface cpfc_cfg_if;
  import cpfc_pkg::*;
  logic                     valid;
  logic                     ready;
  reg_idx_t                 index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/cpfc_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module cpfc_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cpfc_pkg::num_t dividend,
  input  cpfc_pkg::num_t divisor,
  output cpfc_pkg::num_t quotient,
  output cpfc_pkg::num_t remainder,
  output cpfc_pkg::num_t divisor_q,
  output logic          done
);
  import cpfc_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  num_t                    rem;
  num_t                    quo;
  num_t                    dsr;
  logic [NUMBER_BITS:0]    trial;
  logic [NUMBER_BITS:0]    diff;
  logic                    trial_ge;

  assign trial    = {rem, quo[NUMBER_BITS-1]};
  assign diff     = trial - {1'b0, dsr};
  assign trial_ge = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_BITS'(NUMBER_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= trial_ge ? diff[NUMBER_BITS-1:0] : trial[NUMBER_BITS-1:0];
      quo <= {quo[NUMBER_BITS-2:0], trial_ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign divisor_q = dsr;

endmodule

@@ hw/rtl/cpfc_datapath.sv @@
// Datapath: cofactor, wheel candidate, factor bookkeeping, settings and result register.
`timescale 1ns / 1ps

module cpfc_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  cpfc_pkg::dp_cmd_t       cmd,
  output cpfc_pkg::dp_status_t    status,
  input  cpfc_pkg::num_t          number,
  input  logic                    cfg_valid,
  input  cpfc_pkg::reg_idx_t      cfg_index,
  input  logic [cpfc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output cpfc_pkg::count_t        factor_count,
  output logic                    complete,
  output logic                    k_almost,
  output logic                    semiprime,
  output cpfc_pkg::num_t          first_factor,
  output cpfc_pkg::num_t          second_factor,
  output logic                    interesting
);
  import cpfc_pkg::*;

  cap_t   factor_cap;
  pct_t   closeness_percent;
  num_t   rest;
  num_t   cand;
  count_t count;
  num_t   first;
  num_t   second;
  logic   nonzero;
  prod_t  lhs;
  prod_t  rhs;

  num_t   div_sel;
  num_t   quo;
  num_t   rem;
  num_t   dsr;
  logic   div_done;

  logic   note_en;
  num_t   note_val;
  logic   res_complete;
  logic   res_semi;
  logic   res_kal;
  logic   res_inter;

  always_comb begin
    case (cmd.sel)
      PH_TWO:   div_sel = FACTOR_TWO;
      PH_THREE: div_sel = FACTOR_THREE;
      PH_P2:    div_sel = cand + FACTOR_TWO;
      default:  div_sel = cand;
    endcase
  end

  cpfc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.launch),
    .dividend  (rest),
    .divisor   (div_sel),
    .quotient  (quo),
    .remainder (rem),
    .divisor_q (dsr),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_cap        <= CAP_RESET;
      closeness_percent <= PCT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FACTOR_CAP: factor_cap        <= cfg_data[CAP_BITS-1:0];
        REG_CLOSENESS:  closeness_percent <= cfg_data[PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign note_en  = cmd.accept | cmd.final_note;
  assign note_val = cmd.accept ? dsr : rest;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest    <= number;
      cand    <= FIRST_WHEEL;
      count   <= '0;
      first   <= '0;
      second  <= '0;
      nonzero <= (number != '0);
    end else begin
      if (cmd.accept) begin
        rest <= quo;
      end else if (cmd.final_note) begin
        rest <= NUM_ONE;
      end
      if (cmd.advance_p) begin
        cand <= cand + WHEEL_STEP;
      end
      if (note_en) begin
        // The count saturates; every compare against the cap still holds.
        if (count != COUNT_MAX) begin
          count <= count + 1'b1;
        end
        if (first == '0) begin
          first <= note_val;
        end else if (second == '0) begin
          second <= note_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      lhs <= PROD_BITS'(first) * PROD_BITS'(PCT_FULL);
      rhs <= PROD_BITS'(second) * PROD_BITS'(PCT_FULL - closeness_percent);
    end
  end

  assign res_complete = nonzero && (rest == NUM_ONE);
  assign res_semi     = res_complete && (count == COUNT_SEMI);
  assign res_kal      = res_complete && (count >= COUNT_SEMI) &&
                        (count <= COUNT_BITS'(factor_cap));
  assign res_inter    = res_semi && (first != second) &&
                        ((closeness_percent >= PCT_FULL) || (lhs > rhs));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      factor_count  <= count;
      complete      <= res_complete;
      k_almost      <= res_kal;
      semiprime     <= res_semi;
      first_factor  <= first;
      second_factor <= second;
      interesting   <= res_inter;
    end
  end

  assign status.div_done  = div_done;
  assign status.rem_zero  = (rem == '0);
  assign status.q_ge_d    = (quo >= dsr);
  assign status.rest_one  = (rest == NUM_ONE);
  assign status.rest_zero = (rest == '0);
  assign status.below_cap = (count < COUNT_BITS'(factor_cap));

endmodule

@@ hw/rtl/cpfc_controller.sv @@
// Controller: sequences the trial divisions and the result handoff.
`timescale 1ns / 1ps

module cpfc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  cpfc_pkg::dp_status_t status,
  output cpfc_pkg::dp_cmd_t    cmd
);
  import cpfc_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   out_valid;

  logic   ev_accept;
  logic   ev_advance;
  logic   ev_go;
  phase_t ev_phase;
  logic   cont;
  logic   out_free;

  assign cont     = !status.rest_one && status.below_cap;
  assign out_free = !out_valid || rsp_ready;

  // Decision after a division, shared by the next-state and output logic.
  always_comb begin
    ev_accept  = 1'b0;
    ev_advance = 1'b0;
    ev_go      = 1'b0;
    ev_phase   = phase;
    unique case (phase)
      PH_TWO: begin
        ev_accept = status.rem_zero;
        ev_phase  = status.rem_zero ? PH_TWO : PH_THREE;
        ev_go     = 1'b1;
      end
      PH_THREE: begin
        if (status.rem_zero) begin
          ev_accept = 1'b1;
          ev_go     = 1'b1;
        end else begin
          ev_phase = PH_TOP;
          ev_go    = cont;
        end
      end
      PH_TOP: begin
        // The first division by a candidate also tests candidate squared against the cofactor.
        if (status.q_ge_d) begin
          ev_accept = status.rem_zero;
          ev_phase  = status.rem_zero ? PH_P : PH_P2;
          ev_go     = 1'b1;
        end
      end
      PH_P: begin
        if (status.rem_zero) begin
          ev_accept = 1'b1;
          ev_go     = 1'b1;
        end else begin
          ev_phase = PH_P2;
          ev_go    = cont;
        end
      end
      PH_P2: begin
        if (status.rem_zero) begin
          ev_accept = 1'b1;
          ev_go     = 1'b1;
        end else begin
          ev_advance = 1'b1;
          ev_phase   = PH_TOP;
          ev_go      = cont;
        end
      end
      default: ev_go = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_CHECK;
          phase_next = PH_TWO;
        end
      end
      S_CHECK:  state_next = status.rest_zero ? S_PROD : S_LAUNCH;
      S_LAUNCH: state_next = S_WAIT;
      S_WAIT: begin
        if (status.div_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        phase_next = ev_phase;
        state_next = ev_go ? S_LAUNCH : S_FINAL;
      end
      S_FINAL:  state_next = S_PROD;
      S_PROD:   state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.sel        = phase;
    cmd.load       = (state == S_IDLE) && req_valid;
    cmd.launch     = (state == S_LAUNCH);
    cmd.accept     = (state == S_EVAL) && ev_accept;
    cmd.advance_p  = (state == S_EVAL) && ev_advance;
    cmd.final_note = (state == S_FINAL) && cont;
    cmd.prod       = (state == S_PROD);
    cmd.load_out   = (state == S_EMIT) && out_free;
    req_ready      = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_TWO;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp_valid = out_valid;

endmodule

@@ hw/rtl/capped_prime_factor_counter.sv @@
// Top level of the capped prime factor counter.
`timescale 1ns / 1ps

// Factors one number per request by trial division (2, 3, then candidates 6i-1 and 6i+1)
// and reports the factor count, completion, k-almost-prime, semiprime and
// interesting-semiprime flags and the first two factors. One request is worked on at a
// time; every trial division runs on a single restoring divider that yields one quotient
// bit per cycle. A finished result sits in an output register, so the next request is
// taken while it waits. Settings (index 0: factor cap, reset 5; index 1: closeness
// percent, reset 1) must be written only while no request is in progress; the block
// itself does not enforce this.
module capped_prime_factor_counter (
  input logic clk,
  input logic rst,
  cpfc_req_if.sink   req,
  cpfc_rsp_if.source rsp,
  cpfc_cfg_if.sink   cfg
);
  import cpfc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  cpfc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cpfc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .number        (req.number),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .factor_count  (rsp.factor_count),
    .complete      (rsp.complete),
    .k_almost      (rsp.k_almost),
    .semiprime     (rsp.semiprime),
    .first_factor  (rsp.first_factor),
    .second_factor (rsp.second_factor),
    .interesting   (rsp.interesting)
  );

endmodule

@@ hw/rtl/cpfc_checker.sv @@
// Port-level checker for the capped prime factor counter, with its bind.
`timescale 1ns / 1ps

module cpfc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input cpfc_pkg::count_t      factor_count,
  input logic                  complete,
  input logic                  k_almost,
  input logic                  semiprime,
  input cpfc_pkg::num_t        first_factor,
  input cpfc_pkg::num_t        second_factor,
  input logic                  interesting
);
  import cpfc_pkg::*;

  // A stalled result keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(factor_count) && $stable(first_factor)
      && $stable(second_factor) && $stable(interesting))
    else $error("result changed while stalled");

  // A result never appears right after a request.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result appeared one cycle after a request");

  a_semi: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && semiprime |-> complete && (factor_count == COUNT_SEMI))
    else $error("semiprime flag without two factors");

  a_inter: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && interesting |-> semiprime && (first_factor != second_factor))
    else $error("interesting flag without distinct semiprime factors");

  a_kal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && k_almost |-> complete && (factor_count >= COUNT_SEMI)
      && (second_factor != '0))
    else $error("k-almost flag inconsistent with the factors");

endmodule

bind capped_prime_factor_counter cpfc_checker u_cpfc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .factor_count  (rsp.factor_count),
  .complete      (rsp.complete),
  .k_almost      (rsp.k_almost),
  .semiprime     (rsp.semiprime),
  .first_factor  (rsp.first_factor),
  .second_factor (rsp.second_factor),
  .interesting   (rsp.interesting)
);

@@ sim/cpfc_report_checker.sv @@
// Checker that watches the channels, predicts each factoring result and compares it.
`timescale 1ns / 1ps

module cpfc_report_checker (
  input  logic        clk,
  input  logic        rst,
  cpfc_req_if         req,
  cpfc_rsp_if         rsp,
  cpfc_cfg_if         cfg,
  output int unsigned fail_count
);
  import cpfc_pkg::*;

  typedef struct packed {
    count_t factor_count;
    logic   complete;
    logic   k_almost;
    logic   semiprime;
    num_t   first_factor;
    num_t   second_factor;
    logic   interesting;
  } factor_report_t;

  cap_t           cap;
  pct_t           pct;
  factor_report_t pending_reports[$];

  function automatic void record_factor(input longint unsigned f, inout int unsigned cnt,
                                        inout longint unsigned fst,
                                        inout longint unsigned snd);
    cnt++;
    if (fst == 0) fst = f;
    else if (snd == 0) snd = f;
  endfunction

  function automatic void divide_out(input longint unsigned f, inout longint unsigned rest,
                                     inout int unsigned cnt, inout longint unsigned fst,
                                     inout longint unsigned snd);
    while (rest != 0 && rest % f == 0) begin
      rest = rest / f;
      record_factor(f, cnt, fst, snd);
    end
  endfunction

  function automatic factor_report_t factor_number(input num_t n, input cap_t c,
                                                   input pct_t tol);
    factor_report_t    r;
    longint unsigned   rest;
    longint unsigned   p;
    longint unsigned   fst;
    longint unsigned   snd;
    int unsigned       cnt;
    rest = n;
    fst  = 0;
    snd  = 0;
    cnt  = 0;
    if (n != 0) begin
      divide_out(2, rest, cnt, fst, snd);
      divide_out(3, rest, cnt, fst, snd);
      p = 5;
      while (rest != 1 && cnt < c && p <= rest / p) begin
        divide_out(p, rest, cnt, fst, snd);
        if (rest != 1 && cnt < c) divide_out(p + 2, rest, cnt, fst, snd);
        p += 6;
      end
      // Whatever is left above one after the wheel is a prime, if the cap allows it.
      if (rest != 1 && cnt < c) begin
        record_factor(rest, cnt, fst, snd);
        rest = 1;
      end
    end
    r.complete      = (n != 0) && (rest == 1);
    r.semiprime     = r.complete && cnt == 2;
    r.k_almost      = r.complete && cnt >= 2 && cnt <= c;
    r.interesting   = r.semiprime && fst != snd &&
                      (tol >= PCT_FULL || fst * 100 > snd * (100 - longint'(tol)));
    r.factor_count  = (cnt > COUNT_MAX) ? COUNT_MAX : count_t'(cnt);
    r.first_factor  = num_t'(fst);
    r.second_factor = num_t'(snd);
    return r;
  endfunction

  function automatic int unsigned field_diff(input string field, input logic [63:0] want,
                                             input logic [63:0] got);
    if (want === got) return 0;
    $error("%s: expected %0d, got %0d", field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    factor_report_t want;
    int unsigned    errs;
    if (rst) begin
      cap        <= CAP_RESET;
      pct        <= PCT_RESET;
      fail_count <= 0;
      pending_reports.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_FACTOR_CAP) cap <= cap_t'(cfg.data);
        else pct <= pct_t'(cfg.data);
      end
      // Results are checked before this edge's request is queued.
      if (rsp.valid && rsp.ready) begin
        if (pending_reports.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = pending_reports.pop_front();
          errs = 0;
          errs += field_diff("factor_count", want.factor_count, rsp.factor_count);
          errs += field_diff("complete", want.complete, rsp.complete);
          errs += field_diff("k_almost", want.k_almost, rsp.k_almost);
          errs += field_diff("semiprime", want.semiprime, rsp.semiprime);
          errs += field_diff("first_factor", want.first_factor, rsp.first_factor);
          errs += field_diff("second_factor", want.second_factor, rsp.second_factor);
          errs += field_diff("interesting", want.interesting, rsp.interesting);
          fail_count <= fail_count + errs;
        end
      end
      if (req.valid && req.ready) pending_reports.push_back(factor_number(req.number, cap, pct));
    end
  end

endmodule

@@ sim/capped_prime_factor_counter_test.sv @@
// Testbench top: clock, reset, request and setting stimulus, and the verdict.
`timescale 1ns / 1ps

module capped_prime_factor_counter_test;
  import cpfc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned fail_count;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 79;
  cap_t        cur_cap = CAP_RESET;

  cpfc_req_if req_ch ();
  cpfc_rsp_if rsp_ch ();
  cpfc_cfg_if cfg_ch ();

  capped_prime_factor_counter i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  cpfc_report_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) n_results <= n_results + 1;
  end

  function automatic bit is_prime(input int unsigned x);
    if (x < 2) return 0;
    for (int unsigned d = 2; d * d <= x; d++) begin
      if (x % d == 0) return 0;
    end
    return 1;
  endfunction

  function automatic int unsigned prime_from(input int unsigned x);
    while (!is_prime(x)) x++;
    return x;
  endfunction

  // Every kind keeps the wheel short.
  function automatic num_t pick_number(input cap_t c);
    longint unsigned n;
    int unsigned     kind;
    int unsigned     p;
    int unsigned     sh;
    n    = 1;
    kind = $urandom_range(99, 0);
    if (kind < 30) begin
      repeat ($urandom_range(1, (c > 10) ? 12 : c + 2)) begin
        p = prime_from($urandom_range(2, 97));
        if (n * p < (64'd1 << NUMBER_BITS)) n = n * p;
      end
    end else if (kind < 50) begin
      p = prime_from($urandom_range(5, 600));
      if ($urandom_range(3, 0) == 0) n = longint'(p) * p;
      else n = longint'(p) * prime_from(p + 1 + $urandom_range(0, p / 8));
    end else if (kind < 65) begin
      n = longint'($urandom_range(1, 200)) * prime_from($urandom_range(2, 60000));
    end else if (kind < 80) begin
      sh = $urandom_range(1, 16);
      n  = $urandom_range(1, (1 << sh) - 1);
    end else if (kind < 95) begin
      // Wide number: enough factors of two reach a cap of up to 24 before the wheel starts.
      sh = (c > 24) ? 24 : c;
      n  = ({$urandom} & ((64'd1 << NUMBER_BITS) - 1)) >> sh << sh;
      if (n == 0) n = 64'd1 << (NUMBER_BITS - 1);
    end else begin
      case ($urandom_range(3, 0))
        0: n = ($urandom_range(9, 0) == 0) ? 0 : 1;
        1: n = 64'd1 << $urandom_range(0, NUMBER_BITS - 1);
        2: repeat ($urandom_range(19, 0)) n = n * 3;
        default: n = prime_from($urandom_range(2, 3000));
      endcase
    end
    return num_t'(n);
  endfunction

  task automatic send_number(input num_t n);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid  <= 1'b1;
    req_ch.number <= n;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (n_results < n_sent) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_settings(input cap_t c, input pct_t tol);
    logic [CFG_DATA_BITS-CAP_BITS-1:0] junk;
    junk = (CFG_DATA_BITS-CAP_BITS)'($urandom);
    drain;
    // The upper data bits of a cap write are random and must be dropped.
    write_reg(REG_FACTOR_CAP, {junk, c});
    write_reg(REG_CLOSENESS, tol);
    cur_cap = c;
    n_settings++;
  endtask

  initial begin
    num_t at_reset[$];
    num_t at_cap_zero[$];
    num_t at_uncapped[$];
    cap_t caps[6];
    pct_t pcts[6];
    req_ch.valid  = 1'b0;
    req_ch.number = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_FACTOR_CAP;
    cfg_ch.data   = '0;
    at_reset = '{0, 1, 2, 3, 4, 25, 32, 35, 49, 64, 499 * 503, 1616615,
                 2 * prime_from(100000), 1073741823, 1073741824, 1162261467, 2147483646};
    at_cap_zero = '{2147483647, 5, 6, 12, 31'h55555555, 31'h2aaaaaaa};
    at_uncapped = '{6, 15, 1073741824};
    caps = '{1, 2, 0, 31, 0, 3};
    pcts = '{0, 50, 127, 100, 0, 10};
    caps[4] = cap_t'($urandom_range(31, 0));
    pcts[4] = pct_t'($urandom_range(127, 0));

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (at_reset[i]) send_number(at_reset[i]);
    apply_settings(0, 0);
    foreach (at_cap_zero[i]) send_number(at_cap_zero[i]);
    apply_settings(31, 127);
    foreach (at_uncapped[i]) send_number(at_uncapped[i]);

    for (int ph = 0; ph < 6; ph++) begin
      apply_settings(caps[ph], pcts[ph]);
      send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 79 : 0;
      recv_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 30 : 0;
      for (int i = 0; i < 13; i++) begin
        // Hold requests back once per phase until every result is in.
        if (i == 8) drain;
        send_number(pick_number(cur_cap));
      end
    end

    drain;
    repeat (200) @(negedge clk);
    $display("Ran %0d requests under %0d register settings, caps 0 to 31, tolerance 0 to 127.",
             n_sent, n_settings);
    $display("Each side was throttled in turn, then both ran at full rate.");
    if (fail_count == 0 && n_results == n_sent) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cpfc_pkg.sv
hw/rtl/cpfc_ifs.sv
hw/rtl/cpfc_divider.sv
hw/rtl/cpfc_datapath.sv
hw/rtl/cpfc_controller.sv
hw/rtl/capped_prime_factor_counter.sv
hw/rtl/cpfc_checker.sv
sim/cpfc_report_checker.sv
sim/capped_prime_factor_counter_test.sv
